[sv/kabf_pkg.sv]
// shared types, constants and helpers for the angle and bias filter
package kabf_pkg;

   localparam int ST_W = 48;
   localparam int OP_W = 64;
   localparam int CSR_IDX_W = 8;

   typedef logic signed [ST_W-1:0] st_type;
   typedef logic signed [OP_W-1:0] op_type;

   // multiplier request
   typedef struct packed {
      logic   start;
      logic   frac_shift;
      op_type a;
      op_type b;
   } mul_req_type;

   // divider request
   typedef struct packed {
      logic   start;
      st_type num;
      st_type den;
   } div_req_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_Q_ANGLE       = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Q_GYRO        = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_R_ANGLE       = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_PERIOD = 8'd3;

   // register reset values
   localparam logic [47:0] Q_ANGLE_RST       = 48'd1099511628;
   localparam logic [47:0] Q_GYRO_RST        = 48'd3298534883;
   localparam logic [47:0] R_ANGLE_RST       = 48'd549755813888;
   localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd21474836;

   localparam op_type ST_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
   localparam op_type ST_MIN64 = -64'sh0000_8000_0000_0000;

   // clamp a 64 bit signed value to 48 bit signed
   function automatic st_type sat48(input op_type x);
      st_type r;
      if (x > ST_MAX64) r = ST_MAX64[ST_W-1:0];
      else if (x < ST_MIN64) r = ST_MIN64[ST_W-1:0];
      else r = x[ST_W-1:0];
      return r;
   endfunction

endpackage

[sv/kalman_angle_bias_filter.sv]
// top level: sequencer, filter state and registers of the angle and bias filter
//
// Two-state Kalman filter fusing an accelerometer tilt angle with a gyro rate.
// One request transaction yields one response transaction. A sample is
// processed by ten passes through one shared multiplier and two gain
// divisions that produce one quotient bit per cycle, after the request is
// taken and before the response is loaded. req_tready is high only while the
// sequencer is idle; a pending response does not block the next request. The
// csr port takes a write in every cycle; write it only while the filter is idle.
module kalman_angle_bias_filter #(
   parameter int COV_FRAC_BITS = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // accel_angle [31:0], gyro_rate [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // angle_estimate [31:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [kabf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [47:0] csr_data
);
   import kabf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_MWAIT, S_DIV, S_DWAIT, S_OUT
   } state_type;

   // sequence steps
   localparam logic [3:0] OP_PRED_ANGLE = 4'd0;
   localparam logic [3:0] OP_PRED_P00   = 4'd1;
   localparam logic [3:0] OP_PRED_P01   = 4'd2;
   localparam logic [3:0] OP_PRED_P11   = 4'd3;
   localparam logic [3:0] OP_GAIN_K0    = 4'd4;
   localparam logic [3:0] OP_GAIN_K1    = 4'd5;
   localparam logic [3:0] OP_CORR_P00   = 4'd6;
   localparam logic [3:0] OP_CORR_P01   = 4'd7;
   localparam logic [3:0] OP_CORR_P10   = 4'd8;
   localparam logic [3:0] OP_CORR_P11   = 4'd9;
   localparam logic [3:0] OP_CORR_ANGLE = 4'd10;
   localparam logic [3:0] OP_CORR_BIAS  = 4'd11;

   state_type   state_ff;
   logic [3:0]  op_ff;
   logic [47:0] q_angle_ff, q_gyro_ff, r_angle_ff;
   logic [31:0] dt_ff;
   logic [31:0] accel_ff, gyro_ff;
   st_type      angle_ff, bias_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   st_type      k0_ff, k1_ff, t0_ff, t1_ff, e_ff;
   op_type      err_ff;
   logic        rsp_tvalid_ff;
   logic [31:0] rsp_tdata_ff;

   mul_req_type mreq;
   div_req_type dreq;
   logic        mdone, ddone;
   st_type      mres, dres;

   op_type      angle64, bias64, p00_64, p01_64, p10_64, p11_64, m64;
   op_type      accel64, gyro64, dt64;
   st_type      e_now;
   logic signed [49:0] rnd_a;
   logic signed [33:0] out_r;
   logic [31:0] out_sat;

   // widened operands
   always_comb begin
      angle64 = op_type'(angle_ff);
      bias64 = op_type'(bias_ff);
      p00_64 = op_type'(p00_ff);
      p01_64 = op_type'(p01_ff);
      p10_64 = op_type'(p10_ff);
      p11_64 = op_type'(p11_ff);
      m64 = op_type'(mres);
      accel64 = {{16{accel_ff[31]}}, accel_ff, 16'd0};
      gyro64 = {{16{gyro_ff[31]}}, gyro_ff, 16'd0};
      dt64 = {32'd0, dt_ff};
      e_now = sat48(op_type'({16'd0, r_angle_ff}) + p00_64);
   end

   // multiplier operand select
   always_comb begin
      mreq.start = (state_ff == S_MUL);
      mreq.frac_shift = (op_ff >= OP_CORR_P00);
      mreq.a = '0;
      mreq.b = dt64;
      case (op_ff)
         OP_PRED_ANGLE: mreq.a = gyro64 - bias64;
         OP_PRED_P00:   mreq.a = op_type'({16'd0, q_angle_ff}) - p01_64 - p10_64;
         OP_PRED_P01:   mreq.a = -p11_64;
         OP_PRED_P11:   mreq.a = op_type'({16'd0, q_gyro_ff});
         OP_CORR_P00: begin
            mreq.a = op_type'(k0_ff);
            mreq.b = op_type'(t0_ff);
         end
         OP_CORR_P01: begin
            mreq.a = op_type'(k0_ff);
            mreq.b = op_type'(t1_ff);
         end
         OP_CORR_P10: begin
            mreq.a = op_type'(k1_ff);
            mreq.b = op_type'(t0_ff);
         end
         OP_CORR_P11: begin
            mreq.a = op_type'(k1_ff);
            mreq.b = op_type'(t1_ff);
         end
         OP_CORR_ANGLE: begin
            mreq.a = op_type'(k0_ff);
            mreq.b = err_ff;
         end
         OP_CORR_BIAS: begin
            mreq.a = op_type'(k1_ff);
            mreq.b = err_ff;
         end
         default: mreq.a = '0;
      endcase
   end

   // divider operand select
   always_comb begin
      dreq.start = (state_ff == S_DIV);
      dreq.num = (op_ff == OP_GAIN_K0) ? p00_ff : p10_ff;
      dreq.den = (op_ff == OP_GAIN_K0) ? e_now : e_ff;
   end

   // Q16.32 to Q16.16, round half up, clamp
   always_comb begin
      rnd_a = 50'(angle_ff) + 50'sd32768;
      out_r = 34'(rnd_a >>> 16);
      if (out_r > 34'sd2147483647) out_sat = 32'h7FFF_FFFF;
      else if (out_r < -34'sd2147483648) out_sat = 32'h8000_0000;
      else out_sat = out_r[31:0];
   end

   kabf_mul #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_mul (
      .clock(clock), .reset(reset), .req(mreq), .done(mdone), .result(mres)
   );

   kabf_div #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .req(dreq), .done(ddone), .result(dres)
   );

   // sequencer, filter state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= OP_PRED_ANGLE;
         rsp_tvalid_ff <= 1'b0;
         q_angle_ff <= Q_ANGLE_RST;
         q_gyro_ff <= Q_GYRO_RST;
         r_angle_ff <= R_ANGLE_RST;
         dt_ff <= SAMPLE_PERIOD_RST;
         angle_ff <= '0;
         bias_ff <= '0;
         p00_ff <= '0;
         p01_ff <= '0;
         p10_ff <= '0;
         p11_ff <= '0;
      end else begin
         // register writes
         if (csr_valid) begin
            unique case (csr_index)
               REG_Q_ANGLE:       q_angle_ff <= csr_data;
               REG_Q_GYRO:        q_gyro_ff <= csr_data;
               REG_R_ANGLE:       r_angle_ff <= csr_data;
               REG_SAMPLE_PERIOD: dt_ff <= csr_data[31:0];
               default: ;
            endcase
         end

         if (rsp_tvalid_ff && rsp_tready && state_ff != S_OUT) rsp_tvalid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  accel_ff <= req_tdata[31:0];
                  gyro_ff <= req_tdata[63:32];
                  op_ff <= OP_PRED_ANGLE;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: state_ff <= S_MWAIT;
            S_MWAIT: begin
               if (mdone) begin
                  case (op_ff)
                     OP_PRED_ANGLE: angle_ff <= sat48(angle64 + m64);
                     OP_PRED_P00:   p00_ff <= sat48(p00_64 + m64);
                     OP_PRED_P01: begin
                        p01_ff <= sat48(p01_64 + m64);
                        p10_ff <= sat48(p10_64 + m64);
                     end
                     OP_PRED_P11:   p11_ff <= sat48(p11_64 + m64);
                     OP_CORR_P00:   p00_ff <= sat48(p00_64 - m64);
                     OP_CORR_P01:   p01_ff <= sat48(p01_64 - m64);
                     OP_CORR_P10:   p10_ff <= sat48(p10_64 - m64);
                     OP_CORR_P11:   p11_ff <= sat48(p11_64 - m64);
                     OP_CORR_ANGLE: angle_ff <= sat48(angle64 + m64);
                     OP_CORR_BIAS:  bias_ff <= sat48(bias64 + m64);
                     default: ;
                  endcase
                  op_ff <= op_ff + 4'd1;
                  if (op_ff == OP_PRED_P11) state_ff <= S_DIV;
                  else if (op_ff == OP_CORR_BIAS) state_ff <= S_OUT;
                  else state_ff <= S_MUL;
               end
            end
            S_DIV: begin
               // innovation and covariance taken once, after the prediction
               if (op_ff == OP_GAIN_K0) begin
                  e_ff <= e_now;
                  t0_ff <= p00_ff;
                  t1_ff <= p01_ff;
                  err_ff <= accel64 - angle64;
               end
               state_ff <= S_DWAIT;
            end
            S_DWAIT: begin
               if (ddone) begin
                  if (op_ff == OP_GAIN_K0) begin
                     k0_ff <= dres;
                     state_ff <= S_DIV;
                  end else begin
                     k1_ff <= dres;
                     state_ff <= S_MUL;
                  end
                  op_ff <= op_ff + 4'd1;
               end
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff <= out_sat;
                  rsp_tvalid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;
   assign csr_ready = 1'b1;

endmodule

[sv/kabf_mul.sv]
// shared multiplier: 32x32 partial products, rounding shift and saturation
module kabf_mul #(
   parameter int COV_FRAC_BITS = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kabf_pkg::mul_req_type req,
   output logic                 done,
   output kabf_pkg::st_type     result
);
   import kabf_pkg::*;

   logic         busy_ff, busy_in;
   logic         fin_ff, fin_in;
   logic         done_ff, done_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic [63:0]  x_ff, x_in, y_ff, y_in;
   logic         neg_ff, neg_in, frac_ff, frac_in;
   logic [127:0] acc_ff, acc_in;
   st_type       result_ff, result_in;

   logic [31:0]  xs, ys;
   logic [63:0]  pp;
   logic [6:0]   pp_shift;
   logic [127:0] rnd, rsum, shifted, lim, clamped;

   // partial product for the current digit pair
   always_comb begin
      xs = cnt_ff[0] ? x_ff[63:32] : x_ff[31:0];
      ys = cnt_ff[1] ? y_ff[63:32] : y_ff[31:0];
      pp = xs * ys;
      pp_shift = {cnt_ff[0] & cnt_ff[1], cnt_ff[0] ^ cnt_ff[1], 5'b0};
   end

   // round half away from zero, shift, clamp
   always_comb begin
      rnd = frac_ff ? (128'd1 << (COV_FRAC_BITS - 1)) : (128'd1 << 31);
      rsum = acc_ff + rnd;
      shifted = frac_ff ? (rsum >> COV_FRAC_BITS) : (rsum >> 32);
      lim = neg_ff ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
      clamped = (shifted > lim) ? lim : shifted;
   end

   always_comb begin
      busy_in = busy_ff;
      fin_in = 1'b0;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      x_in = x_ff;
      y_in = y_ff;
      neg_in = neg_ff;
      frac_in = frac_ff;
      acc_in = acc_ff;
      result_in = result_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = 2'd0;
         acc_in = '0;
         neg_in = req.a[OP_W-1] ^ req.b[OP_W-1];
         frac_in = req.frac_shift;
         x_in = req.a[OP_W-1] ? 64'(-req.a) : 64'(req.a);
         y_in = req.b[OP_W-1] ? 64'(-req.b) : 64'(req.b);
      end else if (busy_ff) begin
         acc_in = acc_ff + ({64'd0, pp} << pp_shift);
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         result_in = neg_ff ? -st_type'(clamped[ST_W-1:0]) : st_type'(clamped[ST_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         fin_ff <= fin_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      neg_ff <= neg_in;
      frac_ff <= frac_in;
      acc_ff <= acc_in;
      result_ff <= result_in;
   end

   assign done = done_ff;
   assign result = result_ff;

endmodule

[sv/kabf_div.sv]
// gain divider: restoring division, one quotient bit per cycle
module kabf_div #(
   parameter int COV_FRAC_BITS = 40
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kabf_pkg::div_req_type req,
   output logic                 done,
   output kabf_pkg::st_type     result
);
   import kabf_pkg::*;

   localparam int NW = ST_W + COV_FRAC_BITS;
   localparam int CW = $clog2(NW);

   logic            busy_ff, busy_in, fin_ff, fin_in, done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [NW-1:0]   num_ff, num_in, quo_ff, quo_in;
   logic [ST_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic            neg_ff, neg_in, zero_ff, zero_in;
   st_type          result_ff, result_in;

   logic [ST_W:0]   rsh, rdiff;
   logic            ge;
   logic [ST_W-1:0] nmag;
   logic [NW-1:0]   lim, clamped;

   // one restoring step
   always_comb begin
      rsh = {rem_ff, num_ff[NW-1]};
      rdiff = rsh - {1'b0, den_ff};
      ge = (rsh >= {1'b0, den_ff});
      nmag = req.num[ST_W-1] ? ST_W'(-req.num) : ST_W'(req.num);
      lim = neg_ff ? NW'(48'h8000_0000_0000) : NW'(48'h7FFF_FFFF_FFFF);
      clamped = (quo_ff > lim) ? lim : quo_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      fin_in = 1'b0;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      result_in = result_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         num_in = {nmag, {COV_FRAC_BITS{1'b0}}};
         quo_in = '0;
         rem_in = '0;
         den_in = req.den[ST_W-1] ? ST_W'(-req.den) : ST_W'(req.den);
         neg_in = req.num[ST_W-1] ^ req.den[ST_W-1];
         zero_in = (req.den == '0);
      end else if (busy_ff) begin
         rem_in = ge ? rdiff[ST_W-1:0] : rsh[ST_W-1:0];
         num_in = {num_ff[NW-2:0], 1'b0};
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (zero_ff) result_in = '0;
         else if (neg_ff) result_in = -st_type'(clamped[ST_W-1:0]);
         else result_in = st_type'(clamped[ST_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff <= fin_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      zero_ff <= zero_in;
      result_ff <= result_in;
   end

   assign done = done_ff;
   assign result = result_ff;

endmodule

[sv/kabf_checker.sv]
// port-level checks for the angle and bias filter, with bind
module kabf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a request transaction makes the filter busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after request transaction");

   // no response can appear in the cycle after a request
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("response appeared one cycle after request");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // no pending response can exist right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind kalman_angle_bias_filter kabf_checker u_kabf_checker (.*);
